// File: hdl/grid_cell_neighbor_gather_macros.svh
// ----------------------------------------------------------------------------
// grid_cell_neighbor_gather_macros
// Assertion helpers shared by the grid gather block.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_NEIGHBOR_GATHER_MACROS_SVH
`define GRID_CELL_NEIGHBOR_GATHER_MACROS_SVH

// same-cycle implication
`define GCNG_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GCNG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/gcng_pkg.sv
// ----------------------------------------------------------------------------
// gcng_pkg
// Shared types and constants of the grid cell neighbor gather block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcng_pkg;

   localparam int DEF_MAX_GRID_DIM  = 16;
   localparam int DEF_CELL_CAP      = 32;
   localparam int DEF_MAX_NEIGHBORS = 64;

   localparam int ID_W    = 24;
   localparam int COORD_W = 24;
   localparam int SCALE_W = 24;
   localparam int GRID_W  = 5;
   localparam int NBR_W   = 7;
   localparam int CMD_W   = 2;
   localparam int KIND_W  = 3;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 24;
   localparam int PROD_W  = COORD_W + SCALE_W;

   localparam logic [CSR_AW-1:0] REG_GRID_SIZE  = 2'd0;
   localparam logic [CSR_AW-1:0] REG_CELL_SCALE = 2'd1;
   localparam logic [CSR_AW-1:0] REG_MAX_NBR    = 2'd2;

   localparam logic [GRID_W-1:0]  RST_GRID_SIZE  = 5'd16;
   localparam logic [SCALE_W-1:0] RST_CELL_SCALE = 24'd65536;
   localparam logic [NBR_W-1:0]   RST_MAX_NBR    = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERTED = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_NEIGHBOR = 3'd2,
      KIND_NONE     = 3'd3,
      KIND_CLEARED  = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_CLR_RSP,
      ST_IDLE,
      ST_BIN,
      ST_INS_CHK,
      ST_Q_CELL,
      ST_Q_FILL,
      ST_Q_RD,
      ST_Q_EMIT,
      ST_Q_DONE
   } state_type;

endpackage

`default_nettype wire

// File: hdl/gcng_ifs.sv
// ----------------------------------------------------------------------------
// gcng channel interfaces
// Valid/ready channels for request words, response words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcng_req_if import gcng_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [ID_W-1:0]      particle_id;
   logic [COORD_W-1:0]   coord_x;
   logic [COORD_W-1:0]   coord_y;
   logic [COORD_W-1:0]   coord_z;
   modport source (output valid, cmd, particle_id, coord_x, coord_y, coord_z,
                   input ready);
   modport sink   (input valid, cmd, particle_id, coord_x, coord_y, coord_z,
                   output ready);
endinterface

interface gcng_rsp_if import gcng_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [ID_W-1:0]      neighbor_id;
   logic [NBR_W-1:0]     neighbor_count;
   logic                 last;
   modport source (output valid, kind, neighbor_id, neighbor_count, last,
                   input ready);
   modport sink   (input valid, kind, neighbor_id, neighbor_count, last,
                   output ready);
endinterface

interface gcng_csr_if import gcng_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_AW-1:0]    addr;
   logic [CSR_DW-1:0]    wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

// File: hdl/gcng_ram.sv
// ----------------------------------------------------------------------------
// gcng_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gcng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // read data holds while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/gcng_bin.sv
// ----------------------------------------------------------------------------
// gcng_bin
// Shared multiplier that bins the three coordinates one after another.
// ----------------------------------------------------------------------------
`default_nettype none

module gcng_bin import gcng_pkg::*; #(
   parameter int MAX_GRID_DIM = DEF_MAX_GRID_DIM
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [COORD_W-1:0]               coord_x,
   input  wire logic [COORD_W-1:0]               coord_y,
   input  wire logic [COORD_W-1:0]               coord_z,
   input  wire logic [SCALE_W-1:0]               cell_scale,
   input  wire logic [$clog2(MAX_GRID_DIM)-1:0]  gmax,
   output      logic                             done,
   output      logic [$clog2(MAX_GRID_DIM)-1:0]  cell_x,
   output      logic [$clog2(MAX_GRID_DIM)-1:0]  cell_y,
   output      logic [$clog2(MAX_GRID_DIM)-1:0]  cell_z
);

   localparam int CW = $clog2(MAX_GRID_DIM);
   localparam int HI_W = PROD_W - 32;

   logic                busy_ff, busy_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [COORD_W-1:0]  c0_ff, c1_ff, c2_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                pvld_ff, plast_ff, done_ff;
   logic [CW-1:0]       cx_ff, cy_ff, cz_ff;
   logic [HI_W-1:0]     hi;
   logic [CW-1:0]       clamped;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd2) begin
            busy_in = 1'b0;
         end
      end
   end

   // integer part of the Q16.32 product, clamped to the grid
   assign hi      = prod_ff[PROD_W-1:32];
   assign clamped = (hi > HI_W'(gmax)) ? gmax : CW'(hi);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= 2'd0;
         pvld_ff  <= 1'b0;
         plast_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         pvld_ff  <= busy_ff;
         plast_ff <= busy_ff && (cnt_ff == 2'd2);
         done_ff  <= plast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         c0_ff <= coord_x;
         c1_ff <= coord_y;
         c2_ff <= coord_z;
      end else if (busy_ff) begin
         c0_ff <= c1_ff;
         c1_ff <= c2_ff;
      end
      if (busy_ff) begin
         prod_ff <= PROD_W'(c0_ff) * PROD_W'(cell_scale);
      end
      // x comes out first and ends in cx after three shifts
      if (pvld_ff) begin
         cz_ff <= clamped;
         cy_ff <= cz_ff;
         cx_ff <= cy_ff;
      end
   end

   assign done   = done_ff;
   assign cell_x = cx_ff;
   assign cell_y = cy_ff;
   assign cell_z = cz_ff;

endmodule

`default_nettype wire

// File: hdl/grid_cell_neighbor_gather.sv
// A uniform 3D grid of cells, each holding up to CELL_CAP particle ids. Insert
// bins a point and appends its id unless the cell is full; query walks the
// 3x3x3 cells around a point and returns up to max_neighbors ids, at most
// MAX_NEIGHBORS. The binning uses one shared 24x24 multiplier once per axis,
// and the walk reads through the single read port of each cell memory. Clear,
// and likewise the pass that follows reset, sweeps the fill-count memory one
// cell a cycle over all 2^(3*ceil(log2(MAX_GRID_DIM))) cells (4096 by
// default), during which no request word is taken. One request is in work at
// a time; the next one is taken while the final response word still waits in
// the output register.
// ----------------------------------------------------------------------------
// grid_cell_neighbor_gather
// Cell-list binning, insert and 27-cell neighbor gather.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_cell_neighbor_gather_macros.svh"

module grid_cell_neighbor_gather import gcng_pkg::*; #(
   parameter int MAX_GRID_DIM  = DEF_MAX_GRID_DIM,
   parameter int CELL_CAP      = DEF_CELL_CAP,
   parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gcng_req_if.sink   req_ch,
   gcng_rsp_if.source rsp_ch,
   gcng_csr_if.sink   csr_ch
);

   localparam int CW      = $clog2(MAX_GRID_DIM);
   localparam int CELL_AW = 3 * CW;
   localparam int FW      = $clog2(CELL_CAP + 1);
   localparam int EW      = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
   localparam int ENT_AW  = CELL_AW + EW;
   localparam int TW      = CW + 2;

   // configuration
   logic [GRID_W-1:0]  grid_size_ff;
   logic [SCALE_W-1:0] cell_scale_ff;
   logic [NBR_W-1:0]   max_nbr_ff;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [ID_W-1:0]    pid_ff, pid_in;
   logic [1:0]         dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [FW-1:0]      eidx_ff, eidx_in;
   logic [NBR_W-1:0]   n_ff, n_in;
   logic               pend_ff, pend_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic [CELL_AW-1:0] ncell_ff, ncell_in;
   logic [CELL_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic               clr_rsp_ff, clr_rsp_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [NBR_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [CW-1:0]      gmax;
   logic [NBR_W-1:0]   cap;
   logic [5:0]         gs6;

   logic               accept, out_free;
   logic               bin_start, bin_done;
   logic [CW-1:0]      cx, cy, cz;
   logic [TW-1:0]      tx, ty, tz;
   logic               nb_ok, last_off;
   logic [CELL_AW-1:0] nb_cell;

   logic               fill_we, fill_re;
   logic [CELL_AW-1:0] fill_waddr, fill_raddr;
   logic [FW-1:0]      fill_wdata, fill_rdata;
   logic               ent_we, ent_re;
   logic [ENT_AW-1:0]  ent_waddr, ent_raddr;
   logic [ID_W-1:0]    ent_rdata;

   // effective grid and neighbor cap
   assign gs6 = {1'b0, grid_size_ff};
   always_comb begin
      priority if (grid_size_ff == '0) begin
         gmax = '0;
      end else if (gs6 > 6'(MAX_GRID_DIM)) begin
         gmax = CW'(MAX_GRID_DIM - 1);
      end else begin
         gmax = CW'(gs6 - 6'd1);
      end
      priority if (max_nbr_ff == '0) begin
         cap = NBR_W'(1);
      end else if (max_nbr_ff > NBR_W'(MAX_NEIGHBORS)) begin
         cap = NBR_W'(MAX_NEIGHBORS);
      end else begin
         cap = max_nbr_ff;
      end
   end

   // configuration writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff  <= RST_GRID_SIZE;
         cell_scale_ff <= RST_CELL_SCALE;
         max_nbr_ff    <= RST_MAX_NBR;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            REG_GRID_SIZE:  grid_size_ff  <= csr_ch.wdata[GRID_W-1:0];
            REG_CELL_SCALE: cell_scale_ff <= csr_ch.wdata[SCALE_W-1:0];
            REG_MAX_NBR:    max_nbr_ff    <= csr_ch.wdata[NBR_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign bin_start    = accept && ((cmd_type'(req_ch.cmd) == CMD_INSERT) ||
                                    (cmd_type'(req_ch.cmd) == CMD_QUERY));

   gcng_bin #(
      .MAX_GRID_DIM (MAX_GRID_DIM)
   ) u_bin (
      .clock      (clock),
      .reset      (reset),
      .start      (bin_start),
      .coord_x    (req_ch.coord_x),
      .coord_y    (req_ch.coord_y),
      .coord_z    (req_ch.coord_z),
      .cell_scale (cell_scale_ff),
      .gmax       (gmax),
      .done       (bin_done),
      .cell_x     (cx),
      .cell_y     (cy),
      .cell_z     (cz)
   );

   // neighbor cell at offset (d-1) on each axis, skipped when off the grid
   assign tx = TW'(cx) + TW'(dx_ff);
   assign ty = TW'(cy) + TW'(dy_ff);
   assign tz = TW'(cz) + TW'(dz_ff);
   assign nb_ok = (tx != '0) && ((tx - TW'(1)) <= TW'(gmax)) &&
                  (ty != '0) && ((ty - TW'(1)) <= TW'(gmax)) &&
                  (tz != '0) && ((tz - TW'(1)) <= TW'(gmax));
   assign nb_cell  = {CW'(tx - TW'(1)), CW'(ty - TW'(1)), CW'(tz - TW'(1))};
   assign last_off = (dx_ff == 2'd2) && (dy_ff == 2'd2) && (dz_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == '1) begin
               state_in = clr_rsp_ff ? ST_CLR_RSP : ST_IDLE;
            end
         end
         ST_CLR_RSP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req_ch.cmd))
                  CMD_INSERT, CMD_QUERY: state_in = ST_BIN;
                  CMD_CLEAR:             state_in = ST_CLEAR;
                  CMD_NOP:               state_in = ST_IDLE;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_BIN: begin
            if (bin_done) begin
               state_in = (cmd_ff == CMD_INSERT) ? ST_INS_CHK : ST_Q_CELL;
            end
         end
         ST_INS_CHK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_Q_CELL: begin
            priority if (nb_ok) begin
               state_in = ST_Q_FILL;
            end else if (last_off) begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_FILL: state_in = ST_Q_RD;
         ST_Q_RD: begin
            priority if (n_ff == cap) begin
               state_in = ST_Q_DONE;
            end else if (eidx_ff < fill_ff) begin
               state_in = ST_Q_EMIT;
            end else if (last_off) begin
               state_in = ST_Q_DONE;
            end else begin
               state_in = ST_Q_CELL;
            end
         end
         ST_Q_EMIT: begin
            if (!pend_ff || out_free) begin
               state_in = ST_Q_RD;
            end
         end
         ST_Q_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cmd_in       = cmd_ff;
      pid_in       = pid_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      fill_in      = fill_ff;
      eidx_in      = eidx_ff;
      n_in         = n_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      ncell_in     = ncell_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      fill_we      = 1'b0;
      fill_waddr   = clr_cnt_ff;
      fill_wdata   = '0;
      fill_re      = 1'b0;
      fill_raddr   = nb_cell;
      ent_we       = 1'b0;
      ent_waddr    = {ncell_ff, EW'(fill_rdata)};
      ent_re       = 1'b0;
      ent_raddr    = {ncell_ff, eidx_ff[EW-1:0]};

      unique case (state_ff)
         ST_CLEAR: begin
            fill_we    = 1'b1;
            clr_cnt_in = clr_cnt_ff + CELL_AW'(1);
         end
         ST_CLR_RSP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CLEARED;
               rsp_id_in    = '0;
               rsp_cnt_in   = '0;
               rsp_last_in  = 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = cmd_type'(req_ch.cmd);
               pid_in     = req_ch.particle_id;
               clr_cnt_in = '0;
               clr_rsp_in = 1'b1;
            end
         end
         ST_BIN: begin
            dx_in    = 2'd0;
            dy_in    = 2'd0;
            dz_in    = 2'd0;
            n_in     = '0;
            pend_in  = 1'b0;
            ncell_in = {cx, cy, cz};
            fill_re  = bin_done && (cmd_ff == CMD_INSERT);
            fill_raddr = {cx, cy, cz};
         end
         ST_INS_CHK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_cnt_in   = '0;
               rsp_last_in  = 1'b1;
               if (fill_rdata < FW'(CELL_CAP)) begin
                  rsp_kind_in = KIND_INSERTED;
                  ent_we      = 1'b1;
                  fill_we     = 1'b1;
                  fill_waddr  = ncell_ff;
                  fill_wdata  = fill_rdata + FW'(1);
               end else begin
                  rsp_kind_in = KIND_FULL;
               end
            end
         end
         ST_Q_CELL: begin
            if (nb_ok) begin
               fill_re  = 1'b1;
               ncell_in = nb_cell;
            end else if (!last_off) begin
               dz_in = (dz_ff == 2'd2) ? 2'd0 : dz_ff + 2'd1;
               if (dz_ff == 2'd2) begin
                  dy_in = (dy_ff == 2'd2) ? 2'd0 : dy_ff + 2'd1;
                  if (dy_ff == 2'd2) begin
                     dx_in = dx_ff + 2'd1;
                  end
               end
            end
         end
         ST_Q_FILL: begin
            fill_in = fill_rdata;
            eidx_in = '0;
         end
         ST_Q_RD: begin
            priority if (n_ff == cap) begin
               ent_re = 1'b0;
            end else if (eidx_ff < fill_ff) begin
               ent_re = 1'b1;
            end else if (!last_off) begin
               dz_in = (dz_ff == 2'd2) ? 2'd0 : dz_ff + 2'd1;
               if (dz_ff == 2'd2) begin
                  dy_in = (dy_ff == 2'd2) ? 2'd0 : dy_ff + 2'd1;
                  if (dy_ff == 2'd2) begin
                     dx_in = dx_ff + 2'd1;
                  end
               end
            end
         end
         ST_Q_EMIT: begin
            // the held id goes out only once we know another one follows
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_NEIGHBOR;
                  rsp_id_in    = pend_id_ff;
                  rsp_cnt_in   = n_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_in    = 1'b1;
               pend_id_in = ent_rdata;
               n_in       = n_ff + NBR_W'(1);
               eidx_in    = eidx_ff + FW'(1);
            end
         end
         ST_Q_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               pend_in      = 1'b0;
               if (pend_ff) begin
                  rsp_kind_in = KIND_NEIGHBOR;
                  rsp_id_in   = pend_id_ff;
                  rsp_cnt_in  = n_ff;
               end else begin
                  rsp_kind_in = KIND_NONE;
                  rsp_id_in   = '0;
                  rsp_cnt_in  = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_NOP;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff      <= pid_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      fill_ff     <= fill_in;
      eidx_ff     <= eidx_in;
      n_ff        <= n_in;
      pend_id_ff  <= pend_id_in;
      ncell_ff    <= ncell_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   gcng_ram #(
      .WIDTH (FW),
      .DEPTH (2 ** CELL_AW)
   ) u_fill_ram (
      .clock (clock),
      .we    (fill_we),
      .waddr (fill_waddr),
      .wdata (fill_wdata),
      .re    (fill_re),
      .raddr (fill_raddr),
      .rdata (fill_rdata)
   );

   gcng_ram #(
      .WIDTH (ID_W),
      .DEPTH (2 ** ENT_AW)
   ) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (pid_ff),
      .re    (ent_re),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.kind           = rsp_kind_ff;
   assign rsp_ch.neighbor_id    = rsp_id_ff;
   assign rsp_ch.neighbor_count = rsp_cnt_ff;
   assign rsp_ch.last           = rsp_last_ff;

   `GCNG_ASSERT_IMPL(a_bin_in_grid, clock, reset, bin_done,
      (cx <= gmax) && (cy <= gmax) && (cz <= gmax), "binned cell outside grid")
   `GCNG_ASSERT_IMPL(a_count_capped, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == KIND_NEIGHBOR),
      (rsp_cnt_ff != '0) && (rsp_cnt_ff <= cap), "neighbor count out of range")
   `GCNG_ASSERT_IMPL(a_pend_in_query, clock, reset, pend_ff,
      (state_ff == ST_Q_CELL) || (state_ff == ST_Q_FILL) || (state_ff == ST_Q_RD) ||
      (state_ff == ST_Q_EMIT) || (state_ff == ST_Q_DONE), "held id outside query")
   `GCNG_ASSERT_NEXT(a_emit_counts, clock, reset,
      (state_ff == ST_Q_EMIT) && (!pend_ff || out_free),
      (n_ff == $past(n_ff) + NBR_W'(1)) && pend_ff, "emit did not advance count")

endmodule

`default_nettype wire
